// ----- rtl/mcfp_pkg.sv -----
// ----------------------------------------------------------------------------
// mcfp_pkg
// Shared types and constants for the motor command frame packer.
// ----------------------------------------------------------------------------
package mcfp_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned BOUND_W = 31;
	localparam int unsigned INDEX_W = 3;
	localparam int unsigned POS_SLOT_W = 16;
	localparam int unsigned CMD_SLOT_W = 12;
	localparam logic [63:0] EXIT_PAYLOAD = 64'hFFFF_FFFF_FFFF_FFFD;

	typedef enum logic [INDEX_W-1:0] {
		REG_POSITION_LIMIT = 3'd0,
		REG_VELOCITY_LIMIT = 3'd1,
		REG_TORQUE_LIMIT   = 3'd2,
		REG_STIFFNESS_MAX  = 3'd3,
		REG_DAMPING_MAX    = 3'd4
	} reg_index_t;

endpackage

// ----- rtl/mcfp_clamp.sv -----
// ----------------------------------------------------------------------------
// mcfp_clamp
// Saturate one command value to its range; register offset from the low bound.
// ----------------------------------------------------------------------------
module mcfp_clamp #(
	parameter bit SYMMETRIC = 1'b1
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [mcfp_pkg::VALUE_W-1:0] x,
	input  logic [mcfp_pkg::BOUND_W-1:0]      bound,
	output logic [31:0]                       off_s1,
	output logic [31:0]                       span_s1,
	output logic                              clip_s1
);

	logic [mcfp_pkg::BOUND_W-1:0] b;
	logic signed [33:0] xw;
	logic signed [33:0] bw;
	logic signed [33:0] low;
	logic [31:0] off;
	logic [31:0] span;
	logic clip;

	always_comb begin
		// a zero bound acts as one
		b = (bound == '0) ? mcfp_pkg::BOUND_W'(1) : bound;
		xw = 34'(x);
		bw = $signed({3'b000, b});
		low = SYMMETRIC ? -bw : 34'sd0;
		span = SYMMETRIC ? {b, 1'b0} : {1'b0, b};
		if (xw < low) begin
			off = '0;
			clip = 1'b1;
		end else if (xw > bw) begin
			off = span;
			clip = 1'b1;
		end else begin
			off = 32'(xw - low);
			clip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			off_s1 <= off;
			span_s1 <= span;
			clip_s1 <= clip;
		end
	end

endmodule

// ----- rtl/mcfp_div.sv -----
// ----------------------------------------------------------------------------
// mcfp_div
// Scale offset by the full code value, then restoring division by the span,
// one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module mcfp_div #(
	parameter int unsigned CODE_BITS = 12,
	parameter int unsigned QBITS = 16
) (
	input  logic             clk,
	input  logic             en,
	input  logic [31:0]      off,
	input  logic [31:0]      span,
	output logic [QBITS-1:0] quo
);

	localparam int unsigned W = 32 + QBITS;
	localparam logic [W-1:0] FULL = W'((64'd1 << CODE_BITS) - 64'd1);

	logic [W-1:0]     rem_s  [QBITS+1];
	logic [31:0]      span_s [QBITS+1];
	logic [QBITS-1:0] q_s    [QBITS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= W'(off) * FULL;
			span_s[0] <= span;
			q_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < QBITS; j++) begin : g_step
		logic [W-1:0] dv;
		logic ge;
		assign dv = W'(span_s[j]) << (QBITS - 1 - j);
		assign ge = rem_s[j] >= dv;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? rem_s[j] - dv : rem_s[j];
				span_s[j+1] <= span_s[j];
				q_s[j+1] <= {q_s[j][QBITS-2:0], ge};
			end
		end
	end

	assign quo = q_s[QBITS];

endmodule

// ----- rtl/motor_command_frame_packer.sv -----
// ----------------------------------------------------------------------------
// motor_command_frame_packer
// Clamp, quantize and pack one motor command into an 8-byte payload.
// ----------------------------------------------------------------------------
// Accepts one command per clock unless stalled; each payload passes through one
// clamp stage, one multiply stage, one stage per quotient bit of the restoring
// divider, and the output register. The whole pipeline holds while a finished
// payload waits on m_tready. The user must write limits only while idle, on
// cfg_we/cfg_index/cfg_data; the block itself does not enforce this.
module motor_command_frame_packer #(
	parameter int unsigned POSITION_CODE_BITS = 16,
	parameter int unsigned COMMAND_CODE_BITS = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [30:0]   cfg_data,
	input  logic          s_tvalid,
	output logic          s_tready,
	// target_position, target_velocity, stiffness_gain, damping_gain,
	// feedforward_torque (32 bits each, lowest first)
	input  logic [159:0]  s_tdata,
	// exit_request
	input  logic          s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// payload
	output logic [63:0]   m_tdata,
	// clipped
	output logic          m_tuser
);

	localparam int unsigned QBITS = (POSITION_CODE_BITS > COMMAND_CODE_BITS) ?
		POSITION_CODE_BITS : COMMAND_CODE_BITS;
	localparam int unsigned D = QBITS + 3;
	localparam int unsigned NL = 5;

	logic [mcfp_pkg::BOUND_W-1:0] bound_q [NL];
	logic [D-1:0] vld_s;
	logic ext_s [D-1];
	logic clp_s [D-2];
	logic en;
	logic [31:0] off_s1 [NL];
	logic [31:0] span_s1 [NL];
	logic [NL-1:0] clip_s1;
	logic [QBITS-1:0] quo [NL];

	assign en = !vld_s[D-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[D-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q[0] <= 31'd819200;
			bound_q[1] <= 31'd3276800;
			bound_q[2] <= 31'd1179648;
			bound_q[3] <= 31'd32768000;
			bound_q[4] <= 31'd327680;
		end else if (cfg_we) begin
			case (cfg_index)
				mcfp_pkg::REG_POSITION_LIMIT: bound_q[0] <= cfg_data;
				mcfp_pkg::REG_VELOCITY_LIMIT: bound_q[1] <= cfg_data;
				mcfp_pkg::REG_TORQUE_LIMIT:   bound_q[2] <= cfg_data;
				mcfp_pkg::REG_STIFFNESS_MAX:  bound_q[3] <= cfg_data;
				mcfp_pkg::REG_DAMPING_MAX:    bound_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[D-2:0], s_tvalid};
		end
	end

	// lanes: position, velocity, kp, kd, torque
	for (genvar i = 0; i < NL; i++) begin : g_lane
		localparam bit SYM = (i == 0) || (i == 1) || (i == 4);
		localparam int unsigned CB = (i == 0) ? POSITION_CODE_BITS : COMMAND_CODE_BITS;
		localparam int unsigned BI = (i == 4) ? 2 : ((i == 2) ? 3 : ((i == 3) ? 4 : i));

		mcfp_clamp #(.SYMMETRIC(SYM)) u_clamp (
			.clk     (clk),
			.en      (en),
			.x       ($signed(s_tdata[32*i +: 32])),
			.bound   (bound_q[BI]),
			.off_s1  (off_s1[i]),
			.span_s1 (span_s1[i]),
			.clip_s1 (clip_s1[i])
		);

		mcfp_div #(.CODE_BITS(CB), .QBITS(QBITS)) u_div (
			.clk  (clk),
			.en   (en),
			.off  (off_s1[i]),
			.span (span_s1[i]),
			.quo  (quo[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ext_s[0] <= s_tuser;
			clp_s[0] <= |clip_s1;
			for (int k = 1; k < D - 1; k++) begin
				ext_s[k] <= ext_s[k-1];
			end
			for (int k = 1; k < D - 2; k++) begin
				clp_s[k] <= clp_s[k-1];
			end
			if (ext_s[D-2]) begin
				m_tdata <= mcfp_pkg::EXIT_PAYLOAD;
			end else begin
				m_tdata <= {mcfp_pkg::POS_SLOT_W'(quo[0][POSITION_CODE_BITS-1:0]),
					mcfp_pkg::CMD_SLOT_W'(quo[1][COMMAND_CODE_BITS-1:0]),
					mcfp_pkg::CMD_SLOT_W'(quo[2][COMMAND_CODE_BITS-1:0]),
					mcfp_pkg::CMD_SLOT_W'(quo[3][COMMAND_CODE_BITS-1:0]),
					mcfp_pkg::CMD_SLOT_W'(quo[4][COMMAND_CODE_BITS-1:0])};
			end
			m_tuser <= clp_s[D-3];
		end
	end

endmodule
